// ===== rtl/core/clrp_pkg.sv =====
// Shared types and constants for the commit log record parser.
package clrp_pkg;

    // input word kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // result kinds
    localparam logic RK_FIELD  = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_FIELD_SEP  = 2'd0;
    localparam logic [1:0] REG_RECORD_SEP = 2'd1;
    localparam logic [1:0] REG_HASH_LEN   = 2'd2;

    localparam logic [7:0] FIELD_SEP_RST  = 8'd31;
    localparam logic [7:0] RECORD_SEP_RST = 8'd30;
    localparam logic [7:0] HASH_LEN_RST   = 8'd40;

    // status error codes, in priority order
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_BLANK     = 3'd1;
    localparam logic [2:0] ERR_MANY_SEP  = 3'd2;
    localparam logic [2:0] ERR_FEW_SEP   = 3'd3;
    localparam logic [2:0] ERR_HASH_LEN  = 3'd4;
    localparam logic [2:0] ERR_TIME_NONE = 3'd5;
    localparam logic [2:0] ERR_NONDIGIT  = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd7;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_D0 = 8'h30;
    localparam logic [7:0] CH_D9 = 8'h39;

    localparam logic [2:0] SEP_EXPECTED = 3'd5;
    localparam logic [2:0] SEP_SAT      = 3'd6;
    localparam logic [2:0] IDX_HASH     = 3'd0;
    localparam logic [2:0] IDX_TIME     = 3'd4;
    localparam logic [2:0] IDX_SUBJECT  = 3'd5;
    localparam logic [7:0] HASH_CNT_MAX = 8'd255;

    localparam int TIME_W = 63;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic              rkind;
        logic [2:0]        field_index;
        logic [7:0]        out_byte;
        logic              record_ok;
        logic [2:0]        error_code;
        logic [TIME_W-1:0] commit_time;
        logic              last;
    } t_result;

endpackage

// ===== rtl/core/commit_log_record_parser_unit.sv =====
// Commit log record parser: byte stream in, tagged field bytes and record status out.
// Results are written into the registered output queue; none passes combinationally to the output.
// Throughput: one input word per cycle while s_axis_tready is high; the output drains
// one word per cycle while m_axis_tready is high; held CR plus byte takes two slots.
// Input is stalled while the 4-entry output queue has fewer than two free slots.
// Reset (sync, active low) clears the record state and queue, loads config defaults.
module commit_log_record_parser_unit
    import clrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] field_index, [10:3] out_byte, [11] record_ok, [14:12] error_code,
    // [77:15] commit_time, [79:78] zero
    output logic [79:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [FIFO_CW-1:0] FIFO_ROOM = FIFO_CW'(FIFO_DEPTH - 2);

    // configuration
    logic [7:0] r_field_sep, r_record_sep, r_hash_len;

    // record state
    logic              r_nonempty, n_nonempty;
    logic              r_started, n_started;
    logic [2:0]        r_sep_cnt, n_sep_cnt;
    logic [7:0]        r_hash_cnt, n_hash_cnt;
    logic              r_hash_long, n_hash_long;
    logic [TIME_W-1:0] r_time, n_time;
    logic              r_digit_seen, n_digit_seen;
    logic              r_nondigit, n_nondigit;
    logic              r_overflow, n_overflow;
    logic              r_held_cr, n_held_cr;

    // output queue
    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;

    logic        in_acc, out_pop;
    logic [1:0]  kind;
    logic [7:0]  b;
    logic [1:0]  v_n;
    t_result     v_res [2];
    t_result     status_word, cr_word, byte_word;
    logic [2:0]  err;
    logic [2:0]  byte_idx;
    logic [TIME_W+3:0] time_next;
    t_result     head;

    assign kind          = s_axis_tuser;
    assign b             = s_axis_tdata;
    assign s_axis_tready = (r_count <= FIFO_ROOM);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // status built from the state before this word
    always_comb begin
        priority if (!r_started)                                 err = ERR_BLANK;
        else if (r_sep_cnt > SEP_EXPECTED)                       err = ERR_MANY_SEP;
        else if (r_sep_cnt < SEP_EXPECTED)                       err = ERR_FEW_SEP;
        else if (r_hash_long || r_hash_cnt != r_hash_len)        err = ERR_HASH_LEN;
        else if (!r_digit_seen && !r_nondigit)                   err = ERR_TIME_NONE;
        else if (r_nondigit)                                     err = ERR_NONDIGIT;
        else if (r_overflow)                                     err = ERR_OVERFLOW;
        else                                                     err = ERR_OK;
    end

    always_comb begin
        status_word             = '0;
        status_word.rkind       = RK_STATUS;
        status_word.record_ok   = (err == ERR_OK);
        status_word.error_code  = err;
        status_word.commit_time = (err == ERR_OK) ? r_time : '0;

        cr_word             = '0;
        cr_word.rkind       = RK_FIELD;
        cr_word.field_index = IDX_SUBJECT;
        cr_word.out_byte    = CH_CR;

        byte_idx            = (r_sep_cnt > IDX_SUBJECT) ? IDX_SUBJECT : r_sep_cnt;
        byte_word             = '0;
        byte_word.rkind       = RK_FIELD;
        byte_word.field_index = byte_idx;
        byte_word.out_byte    = b;
    end

    // time * 10 + digit as shift-add; any bit at or above 63 is overflow
    assign time_next = {1'b0, r_time, 3'b000} + {3'b000, r_time, 1'b0}
                     + {{(TIME_W - 4){1'b0}}, b - CH_D0};

    always_comb begin
        n_nonempty   = r_nonempty;
        n_started    = r_started;
        n_sep_cnt    = r_sep_cnt;
        n_hash_cnt   = r_hash_cnt;
        n_hash_long  = r_hash_long;
        n_time       = r_time;
        n_digit_seen = r_digit_seen;
        n_nondigit   = r_nondigit;
        n_overflow   = r_overflow;
        n_held_cr    = r_held_cr;
        v_n          = 2'd0;
        v_res[0]     = status_word;
        v_res[1]     = byte_word;

        if (in_acc) begin
            if (kind == KIND_ABORT || kind == KIND_FLUSH
                || (kind == KIND_BYTE && b == r_record_sep)) begin
                if (kind != KIND_ABORT && r_nonempty) begin
                    v_res[0] = status_word;
                    v_n      = 2'd1;
                end
                n_nonempty   = 1'b0;
                n_started    = 1'b0;
                n_sep_cnt    = '0;
                n_hash_cnt   = '0;
                n_hash_long  = 1'b0;
                n_time       = '0;
                n_digit_seen = 1'b0;
                n_nondigit   = 1'b0;
                n_overflow   = 1'b0;
                n_held_cr    = 1'b0;
            end else if (kind == KIND_BYTE) begin
                n_nonempty = 1'b1;
                if (!(!r_started && (b == CH_CR || b == CH_LF))) begin
                    n_started = 1'b1;
                    if (r_held_cr) begin
                        v_res[0]  = cr_word;
                        v_n       = 2'd1;
                        n_held_cr = 1'b0;
                    end
                    if (b == r_field_sep) begin
                        if (r_sep_cnt < SEP_SAT) n_sep_cnt = r_sep_cnt + 3'd1;
                    end else begin
                        if (r_sep_cnt == IDX_HASH) begin
                            if (r_hash_cnt == HASH_CNT_MAX) n_hash_long = 1'b1;
                            else                            n_hash_cnt  = r_hash_cnt + 8'd1;
                        end else if (r_sep_cnt == IDX_TIME && !r_nondigit) begin
                            if (b < CH_D0 || b > CH_D9) begin
                                n_nondigit = 1'b1;
                            end else begin
                                n_digit_seen = 1'b1;
                                if (!r_overflow) begin
                                    if (time_next[TIME_W+3:TIME_W] != 4'd0)
                                        n_overflow = 1'b1;
                                    else
                                        n_time = time_next[TIME_W-1:0];
                                end
                            end
                        end
                        if (b == CH_CR && r_sep_cnt == SEP_EXPECTED) begin
                            n_held_cr = 1'b1;
                        end else begin
                            v_res[v_n[0]] = byte_word;
                            v_n           = v_n + 2'd1;
                        end
                    end
                end
            end
        end

        if (v_n == 2'd1) v_res[0].last = 1'b1;
        if (v_n == 2'd2) v_res[1].last = 1'b1;
    end

    assign out_pop = m_axis_tvalid && m_axis_tready;
    assign n_count = r_count + FIFO_CW'(v_n) - FIFO_CW'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_sep  <= FIELD_SEP_RST;
            r_record_sep <= RECORD_SEP_RST;
            r_hash_len   <= HASH_LEN_RST;
            r_nonempty   <= 1'b0;
            r_started    <= 1'b0;
            r_sep_cnt    <= '0;
            r_hash_cnt   <= '0;
            r_hash_long  <= 1'b0;
            r_time       <= '0;
            r_digit_seen <= 1'b0;
            r_nondigit   <= 1'b0;
            r_overflow   <= 1'b0;
            r_held_cr    <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_FIELD_SEP:  r_field_sep  <= i_cfg_data;
                    REG_RECORD_SEP: r_record_sep <= i_cfg_data;
                    REG_HASH_LEN:   r_hash_len   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_nonempty   <= n_nonempty;
            r_started    <= n_started;
            r_sep_cnt    <= n_sep_cnt;
            r_hash_cnt   <= n_hash_cnt;
            r_hash_long  <= n_hash_long;
            r_time       <= n_time;
            r_digit_seen <= n_digit_seen;
            r_nondigit   <= n_nondigit;
            r_overflow   <= n_overflow;
            r_held_cr    <= n_held_cr;
            r_wr_ptr     <= r_wr_ptr + FIFO_AW'(v_n);
            r_rd_ptr     <= r_rd_ptr + FIFO_AW'(out_pop);
            r_count      <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (v_n != 2'd0) r_mem[r_wr_ptr] <= v_res[0];
        if (v_n == 2'd2) r_mem[r_wr_ptr + FIFO_AW'(1)] <= v_res[1];
    end

    assign head          = r_mem[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {2'b00, head.commit_time, head.error_code, head.record_ok,
                            head.out_byte, head.field_index};
    assign m_axis_tuser  = head.rkind;
    assign m_axis_tlast  = head.last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_held_cr_subject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cr |-> (r_started && r_sep_cnt == SEP_EXPECTED))
        else $error("held CR outside subject field");

    a_sep_needs_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sep_cnt != 3'd0 || r_hash_cnt != 8'd0) |-> (r_started && r_nonempty))
        else $error("field progress without started record");

    a_ok_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[11])
            |-> (m_axis_tdata[14:12] == ERR_OK))
        else $error("accepted record carries an error code");
`endif

endmodule
